// ----- sv/assert_macros.svh -----
// Assertion macros shared by the maze carver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check with a clock and an active-low reset that masks the property.
`define MDC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that also holds while reset is applied.
`define MDC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MDC_ASSERT(name, clk, rst_n, prop, msg)
`define MDC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ----- sv/mdc_pkg.sv -----
// Types and constants for the maze carver.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mdc_pkg;

    // directions, same coding on input and output
    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] DIM_RESET = 7'd8;

    // visited map holds an epoch tag per cell
    localparam int TAG_W = 8;

    localparam int FROM_W  = 12;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic              underflow_error;
        logic              finished;
        logic              backtracked;
        logic [1:0]        carve_direction;
        logic [FROM_W-1:0] from_cell;
        logic              carved;
    } result_t;

    localparam int RES_W = $bits(result_t);

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'b001,
        ST_READ    = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

endpackage

// ----- sv/mdc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/random_dfs_maze_carver_top.sv -----
// Maze carver top level: randomized depth-first walk with a backtrack stack.
// Depends on mdc_pkg, mdc_ram and assert_macros.svh.
//
//  channel | ports                          | beat contents (low bit up)
//  --------+--------------------------------+-------------------------------------------
//  draw in | s_tvalid s_tready s_tdata s_tuser | tdata: random_direction; tuser: command
//  result  | m_tvalid m_tready m_tdata      | carved, from_cell, carve_direction,
//          |                                | backtracked, finished, underflow_error
//  config  | cfg_valid cfg_ready cfg_addr cfg_data | 0 grid_width, 1 grid_height
//
// A new draw is taken only after the last one is resolved: the visited-tag and stack RAMs are read in the accept
// cycle and the walk state is resolved and written back in the next one.
// After reset, and after every 255th restart (epoch tag wrap), a clearing pass
// sweeps all MAX_WIDTH*MAX_HEIGHT cells of the visited RAM; no draw is taken then.
// A two-beat result queue lets draws continue while a result waits on m_tready.
// Config writes are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module random_dfs_maze_carver_top
    import mdc_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // draw channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] random_direction, rest zero
    input  logic                 s_tuser,   // [0] command
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] carved, [12:1] from_cell,
                                            // [14:13] carve_direction, [15] backtracked,
                                            // [16] finished, [17] underflow_error
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SDW   = $clog2(CELLS + 1);
    localparam int SEW   = XW + YW;

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] grid_w_reg, grid_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= DIM_RESET;
            grid_h_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_GRID_WIDTH:  grid_w_reg <= cfg_data;
                CFG_GRID_HEIGHT: grid_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    // zero reads as one, oversize clamps to the maximum
    always_comb begin
        if (grid_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(grid_w_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(grid_w_reg);
        end
        if (grid_h_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(grid_h_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(grid_h_reg);
        end
    end

    // ------------------------------------------------------------ walk state
    state_t            state_reg, state_next;
    logic [XW-1:0]     pos_x_reg, pos_x_next;
    logic [YW-1:0]     pos_y_reg, pos_y_next;
    logic [SDW-1:0]    depth_reg, depth_next;
    logic [3:0]        failed_reg, failed_next;
    logic [AW-1:0]     count_reg, count_next;
    logic              done_reg, done_next;
    logic [TAG_W-1:0]  epoch_reg, epoch_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        out_cnt_reg, out_cnt_next;

    // ---------------------------------------------------- accept-cycle logic
    logic          accept;
    logic          cmd_in;
    dir_t          dir_in;
    logic [XW:0]   nxe;
    logic [YW:0]   nye;
    logic          edge_ok;
    logic          inb;
    logic [AW-1:0] vis_raddr;
    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] target;
    logic [FROM_W-1:0] from_idx;

    assign s_tready = (state_reg == ST_READ) && (out_cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign cmd_in   = s_tuser;
    assign dir_in   = dir_t'(s_tdata[1:0]);

    always_comb begin
        nxe     = {1'b0, pos_x_reg};
        nye     = {1'b0, pos_y_reg};
        edge_ok = 1'b1;
        case (dir_in)
            DIR_NORTH: begin
                nye     = {1'b0, pos_y_reg} - (YW+1)'(1);
                edge_ok = (pos_y_reg != '0);
            end
            DIR_EAST: begin
                nxe = {1'b0, pos_x_reg} + (XW+1)'(1);
            end
            DIR_SOUTH: begin
                nye = {1'b0, pos_y_reg} + (YW+1)'(1);
            end
            DIR_WEST: begin
                nxe     = {1'b0, pos_x_reg} - (XW+1)'(1);
                edge_ok = (pos_x_reg != '0);
            end
            default: ;
        endcase
    end

    assign inb = edge_ok && (32'(nxe) < 32'(w_eff)) && (32'(nye) < 32'(h_eff));

    // visited RAM is laid out with a fixed row stride of MAX_WIDTH
    assign vis_raddr = AW'(32'(nye[YW-1:0]) * MAX_WIDTH + 32'(nxe[XW-1:0]));
    assign stk_raddr = AW'(depth_reg - SDW'(1));
    assign target    = AW'(32'(w_eff) * 32'(h_eff) - 32'd1);
    assign from_idx  = FROM_W'(32'(pos_y_reg) * 32'(w_eff) + 32'(pos_x_reg));

    // registered hand-over to the resolve cycle
    logic              r_cmd, r_inb, r_done;
    dir_t              r_dir;
    logic [XW-1:0]     r_nx;
    logic [YW-1:0]     r_ny;
    logic [AW-1:0]     r_vis_addr;
    logic [AW-1:0]     r_target;
    logic [FROM_W-1:0] r_from;

    always_ff @(posedge aclk) begin
        if (accept) begin
            r_cmd      <= cmd_in;
            r_dir      <= dir_in;
            r_nx       <= nxe[XW-1:0];
            r_ny       <= nye[YW-1:0];
            r_inb      <= inb;
            r_done     <= done_reg || (count_reg >= target);
            r_vis_addr <= vis_raddr;
            r_target   <= target;
            r_from     <= from_idx;
        end
    end

    // ------------------------------------------------------------- memories
    logic             vis_we;
    logic [AW-1:0]    vis_waddr;
    logic [TAG_W-1:0] vis_wdata;
    logic [TAG_W-1:0] vis_rdata;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    logic [SEW-1:0]   stk_wdata;
    logic [SEW-1:0]   stk_rdata;

    mdc_ram #(.WIDTH(TAG_W), .DEPTH(CELLS)) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    mdc_ram #(.WIDTH(SEW), .DEPTH(CELLS)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // --------------------------------------------------- resolve-cycle logic
    result_t       res;
    logic          visited;
    logic          carve;
    logic [3:0]    failed_or;
    logic [AW-1:0] count_inc;

    // origin is visited in every epoch
    assign visited   = (vis_rdata == epoch_reg) || ((r_nx == '0) && (r_ny == '0));
    assign carve     = r_inb && !visited;
    assign failed_or = failed_reg | (4'b0001 << r_dir);
    assign count_inc = count_reg + AW'(1);

    always_comb begin
        state_next  = state_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        depth_next  = depth_reg;
        failed_next = failed_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        epoch_next  = epoch_reg;
        clr_next    = clr_reg;
        res         = '0;
        vis_we      = 1'b0;
        vis_waddr   = r_vis_addr;
        vis_wdata   = epoch_reg;
        stk_we      = 1'b0;
        stk_waddr   = AW'(depth_reg);
        stk_wdata   = {pos_y_reg, pos_x_reg};

        case (state_reg)
            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (accept) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                state_next = ST_READ;
                if (r_cmd) begin
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    depth_next  = '0;
                    failed_next = '0;
                    count_next  = '0;
                    done_next   = 1'b0;
                    // a fresh epoch empties the map; on wrap, sweep it instead
                    if (epoch_reg == '1) begin
                        epoch_next = TAG_W'(1);
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + TAG_W'(1);
                    end
                end else if (r_done) begin
                    done_next = 1'b1;
                end else if (carve) begin
                    if (32'(depth_reg) < CELLS) begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + SDW'(1);
                    end
                    vis_we              = 1'b1;
                    res.carved          = 1'b1;
                    res.from_cell       = r_from;
                    res.carve_direction = r_dir;
                    pos_x_next          = r_nx;
                    pos_y_next          = r_ny;
                    failed_next         = '0;
                    count_next          = count_inc;
                    if (count_inc >= r_target) begin
                        done_next = 1'b1;
                    end
                end else begin
                    failed_next = failed_or;
                    if (failed_or == 4'hF) begin
                        failed_next = '0;
                        if (depth_reg == '0) begin
                            res.underflow_error = 1'b1;
                        end else begin
                            depth_next      = depth_reg - SDW'(1);
                            pos_x_next      = stk_rdata[XW-1:0];
                            pos_y_next      = stk_rdata[SEW-1:XW];
                            res.backtracked = 1'b1;
                        end
                    end
                end
                res.finished = done_next || (count_next >= r_target);
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // ---------------------------------------------------------- result queue
    logic             push, pop;
    logic [RES_W-1:0] q0_reg, q0_next;
    logic [RES_W-1:0] q1_reg, q1_next;

    assign push = (state_reg == ST_RESOLVE);
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        q0_next      = q0_reg;
        q1_next      = q1_reg;
        out_cnt_next = out_cnt_reg;
        if (pop && (out_cnt_reg == 2'd2)) begin
            q0_next = q1_reg;
        end
        if (push) begin
            if ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && pop)) begin
                q0_next = res;
            end else begin
                q1_next = res;
            end
        end
        case ({push, pop})
            2'b10:   out_cnt_next = out_cnt_reg + 2'd1;
            2'b01:   out_cnt_next = out_cnt_reg - 2'd1;
            default: out_cnt_next = out_cnt_reg;
        endcase
    end

    assign m_tvalid = (out_cnt_reg != 2'd0);
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), q0_reg};

    // ------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            depth_reg   <= '0;
            failed_reg  <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            epoch_reg   <= TAG_W'(1);
            clr_reg     <= '0;
            out_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            depth_reg   <= depth_next;
            failed_reg  <= failed_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            epoch_reg   <= epoch_next;
            clr_reg     <= clr_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // ------------------------------------------------------------ assertions
    `MDC_ASSERT(a_queue_room, aclk, aresetn, (state_reg == ST_RESOLVE) |-> (out_cnt_reg != 2'd2), "result beat pushed into a full queue")
    `MDC_ASSERT(a_accept_resolves, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_RESOLVE), "accepted draw not resolved in the next cycle")
    `MDC_ASSERT(a_depth_cap, aclk, aresetn, 32'(depth_reg) <= CELLS, "backtrack stack depth beyond capacity")
    `MDC_ASSERT(a_epoch_live, aclk, aresetn, epoch_reg != '0, "epoch tag zero would match cleared cells")
    `MDC_ASSERT(a_pop_flags, aclk, aresetn, (state_reg == ST_RESOLVE) |-> !(res.backtracked && res.underflow_error), "backtrack and underflow flagged together")

endmodule

// ----- tb/tb_random_dfs_maze_carver_top.sv -----
// Self-checking testbench for the maze carver: a directed opener, then random walk phases.
// Depends on mdc_pkg and random_dfs_maze_carver_top; results are predicted as items are queued.
`timescale 1ns / 1ps

module tb_random_dfs_maze_carver_top;
    import mdc_pkg::*;

    localparam int GRID_MAX  = 64;
    localparam int RUN_LIMIT = 600000;

    typedef struct {
        bit   restart;
        dir_t dir;
    } draw_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [1:0] random_direction
    logic                 s_tuser = 1'b0; // [0] command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // carved, from_cell, carve_direction, backtracked,
                                          // finished, underflow_error
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_addr = CFG_GRID_WIDTH;
    logic [CFG_W-1:0]     cfg_data = DIM_RESET;

    draw_t   draw_q[$];
    result_t carve_expect_q[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int cycle_count   = 0;

    // shadow of the carver state
    bit               maze_visited [GRID_MAX][GRID_MAX];
    int               trail_x [GRID_MAX*GRID_MAX];
    int               trail_y [GRID_MAX*GRID_MAX];
    int               trail_depth;
    int               cur_x, cur_y;
    int               carves;
    logic [3:0]       dir_failed;
    bit               walk_done;
    logic [CFG_W-1:0] width_reg  = DIM_RESET;
    logic [CFG_W-1:0] height_reg = DIM_RESET;

    random_dfs_maze_carver_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic int grid_dim(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > GRID_MAX) return GRID_MAX;
        return int'(r);
    endfunction

    function automatic void walk_reset();
        foreach (maze_visited[i, j]) maze_visited[i][j] = 1'b0;
        maze_visited[0][0] = 1'b1;
        trail_depth = 0;
        cur_x       = 0;
        cur_y       = 0;
        dir_failed  = '0;
        carves      = 0;
        walk_done   = 1'b0;
    endfunction

    function automatic bit walk_finished();
        return walk_done || carves >= grid_dim(width_reg) * grid_dim(height_reg) - 1;
    endfunction

    function automatic void neighbor_of(dir_t d, output int nx, output int ny);
        nx = cur_x;
        ny = cur_y;
        case (d)
            DIR_NORTH: ny = ny - 1;
            DIR_EAST:  nx = nx + 1;
            DIR_SOUTH: ny = ny + 1;
            default:   nx = nx - 1;
        endcase
    endfunction

    function automatic bit can_carve(dir_t d);
        int nx, ny;
        neighbor_of(d, nx, ny);
        return nx >= 0 && nx < grid_dim(width_reg) && ny >= 0 && ny < grid_dim(height_reg)
               && !maze_visited[ny][nx];
    endfunction

    function automatic result_t maze_step(bit restart, dir_t d);
        result_t r;
        int      nx, ny;
        r = '0;
        if (restart) begin
            walk_reset();
        end else if (walk_finished()) begin
            walk_done = 1'b1;
        end else if (can_carve(d)) begin
            if (trail_depth < GRID_MAX * GRID_MAX) begin
                trail_x[trail_depth] = cur_x;
                trail_y[trail_depth] = cur_y;
                trail_depth++;
            end
            r.carved          = 1'b1;
            r.from_cell       = FROM_W'(cur_y * grid_dim(width_reg) + cur_x);
            r.carve_direction = d;
            neighbor_of(d, nx, ny);
            cur_x = nx;
            cur_y = ny;
            maze_visited[ny][nx] = 1'b1;
            dir_failed = '0;
            carves++;
            if (walk_finished()) walk_done = 1'b1;
        end else begin
            dir_failed[d] = 1'b1;
            if (&dir_failed) begin
                dir_failed = '0;
                if (trail_depth == 0) begin
                    r.underflow_error = 1'b1;
                end else begin
                    trail_depth--;
                    cur_x = trail_x[trail_depth];
                    cur_y = trail_y[trail_depth];
                    r.backtracked = 1'b1;
                end
            end
        end
        r.finished = walk_finished();
        return r;
    endfunction

    // prefer an open passage, then a direction not yet failed
    function automatic dir_t pick_direction();
        dir_t opts[$];
        for (int k = 0; k < 4; k++)
            if (can_carve(dir_t'(k))) opts = {opts, dir_t'(k)};
        if (opts.size() == 0)
            for (int k = 0; k < 4; k++)
                if (!dir_failed[k]) opts = {opts, dir_t'(k)};
        if (opts.size() == 0) return dir_t'($urandom_range(3));
        return opts[$urandom_range(opts.size() - 1)];
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic queue_draw(bit restart, dir_t d);
        draw_t it;
        it.restart = restart;
        it.dir     = d;
        draw_q = {draw_q, it};
        carve_expect_q = {carve_expect_q, maze_step(restart, d)};
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (draw_q.size() != 0 || s_tvalid || carve_expect_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_idle(int mode);
        send_idle_pct = (mode == 1) ? 58 : (mode == 3) ? 36 : 0;
        stall_pct     = (mode == 2) ? 58 : (mode == 3) ? 36 : 0;
    endtask

    task automatic program_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= CFG_GRID_WIDTH;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_addr <= CFG_GRID_HEIGHT;
        cfg_data <= h;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    task automatic walk_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int mode, int n_items);
        bit restart;
        program_grid(w, h);
        set_idle(mode);
        for (int k = 0; k < n_items; k++) begin
            if (k == 0) restart = ($urandom_range(1) == 1);   // half the phases keep the old walk
            else if (walk_finished()) restart = ($urandom_range(3) == 0);
            else restart = ($urandom_range(199) == 0);
            if (restart) queue_draw(1'b1, dir_t'($urandom_range(3)));
            else if ($urandom_range(99) < 75) queue_draw(1'b0, pick_direction());
            else queue_draw(1'b0, dir_t'($urandom_range(3)));
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        draw_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (draw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = draw_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W-2){1'b0}}, nxt.dir};
                s_tuser  <= nxt.restart;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (carve_expect_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = carve_expect_q.pop_front();
                    check_field("carved", want.carved, got.carved);
                    check_field("from_cell", want.from_cell, got.from_cell);
                    check_field("carve_direction", want.carve_direction, got.carve_direction);
                    check_field("backtracked", want.backtracked, got.backtracked);
                    check_field("finished", want.finished, got.finished);
                    check_field("underflow_error", want.underflow_error, got.underflow_error);
                    check_field("tdata padding", 0, int'(m_tdata[M_TDATA_W-1:RES_W]));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        walk_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // open a few passages on the reset grid, bump into visited and outside cells
        queue_draw(1'b0, DIR_NORTH);
        queue_draw(1'b0, DIR_WEST);
        queue_draw(1'b0, DIR_EAST);
        queue_draw(1'b0, DIR_SOUTH);
        queue_draw(1'b0, DIR_WEST);
        queue_draw(1'b0, DIR_NORTH);
        queue_draw(1'b1, DIR_WEST);

        // fail three ways on a single column, the last way on a single row:
        // all four failed at the origin with an empty stack
        program_grid(7'd1, 7'd8);
        queue_draw(1'b0, DIR_NORTH);
        queue_draw(1'b0, DIR_EAST);
        queue_draw(1'b0, DIR_WEST);
        program_grid(7'd8, 7'd1);
        queue_draw(1'b0, DIR_SOUTH);
        queue_draw(1'b0, DIR_EAST);
        queue_draw(1'b1, DIR_NORTH);

        // zero dimensions act as a 1x1 grid, finished at once
        program_grid(7'd0, 7'd0);
        queue_draw(1'b0, DIR_EAST);
        queue_draw(1'b1, DIR_SOUTH);

        // oversized dimensions clamp; then shrink below the carve count and grow back
        program_grid(7'd127, 7'd127);
        queue_draw(1'b0, DIR_EAST);
        queue_draw(1'b0, DIR_SOUTH);
        program_grid(7'd1, 7'd2);
        queue_draw(1'b0, DIR_NORTH);
        program_grid(7'd64, 7'd64);
        queue_draw(1'b0, DIR_SOUTH);
        queue_draw(1'b1, DIR_EAST);

        walk_phase(7'd8,   7'd8,   0, 300);
        walk_phase(7'd4,   7'd4,   1, 120);
        walk_phase(7'd2,   7'd3,   2, 60);
        walk_phase(7'd1,   7'd1,   3, 20);
        walk_phase(7'd0,   7'd9,   0, 60);
        walk_phase(7'd127, 7'd2,   1, 100);
        walk_phase(7'd3,   7'd3,   2, 90);
        walk_phase(7'd64,  7'd64,  3, 150);
        walk_phase(7'd5,   7'd6,   0, 150);
        walk_phase(7'd1,   7'd64,  1, 80);
        walk_phase(7'd100, 7'd1,   2, 60);
        walk_phase(7'd6,   7'd6,   3, 200);
        walk_phase(7'd2,   7'd2,   1, 40);
        walk_phase(7'd8,   7'd8,   3, 220);

        do @(negedge aclk);
        while (draw_q.size() != 0 || s_tvalid || carve_expect_q.size() != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
